/* hdl/life_generation_row_stream_top_macros.svh */
`ifndef LIFE_GENERATION_ROW_STREAM_TOP_MACROS_SVH
`define LIFE_GENERATION_ROW_STREAM_TOP_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define LGRS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lgrs assertion failed");

// Check a consequent in the cycle after its antecedent.
`define LGRS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lgrs assertion failed");

`endif

/* hdl/lgrs_pkg.sv */
package lgrs_pkg;

   localparam int ROW_W         = 64;
   localparam int GRID_WIDTH    = 64;
   localparam int NBR_COUNT     = 8;
   localparam int NBR_W         = $clog2(NBR_COUNT + 1);
   localparam int BIRTH_COUNT   = 3;
   localparam int SURVIVE_COUNT = 2;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic load;
      logic held;
   } cell_ctl_type;

   typedef struct packed {
      logic first;
      logic second;
   } push_type;

   typedef struct packed {
      logic [ROW_W-1:0] cells;
      logic             frame_end;
   } result_type;

endpackage

/* hdl/lgrs_cell.sv */
module lgrs_cell (
   input  logic                  clock,
   input  lgrs_pkg::cell_ctl_type ctl,
   input  logic                  row_bit,
   input  logic                  row_left,
   input  logic                  row_right,
   input  logic                  above_left,
   input  logic                  above_right,
   input  logic                  mid_left,
   input  logic                  mid_right,
   output logic                  above_bit,
   output logic                  mid_bit,
   output logic                  next_bit,
   output logic                  tail_bit
);

   logic                      above_ff, above_in;
   logic                      mid_ff, mid_in;
   logic [lgrs_pkg::NBR_W-1:0] n_mid;
   logic [lgrs_pkg::NBR_W-1:0] n_tail;
   logic                      up_c, up_l, up_r;

   assign above_bit = above_ff;
   assign mid_bit   = mid_ff;

   assign n_mid = lgrs_pkg::NBR_W'(above_left) + lgrs_pkg::NBR_W'(above_ff)
                + lgrs_pkg::NBR_W'(above_right) + lgrs_pkg::NBR_W'(mid_left)
                + lgrs_pkg::NBR_W'(mid_right) + lgrs_pkg::NBR_W'(row_left)
                + lgrs_pkg::NBR_W'(row_bit) + lgrs_pkg::NBR_W'(row_right);

   // row above the final row is the held middle row, if any
   assign up_c = ctl.held & mid_ff;
   assign up_l = ctl.held & mid_left;
   assign up_r = ctl.held & mid_right;

   assign n_tail = lgrs_pkg::NBR_W'(up_l) + lgrs_pkg::NBR_W'(up_c)
                 + lgrs_pkg::NBR_W'(up_r) + lgrs_pkg::NBR_W'(row_left)
                 + lgrs_pkg::NBR_W'(row_right);

   assign next_bit = (n_mid == lgrs_pkg::NBR_W'(lgrs_pkg::BIRTH_COUNT))
                   | (mid_ff & (n_mid == lgrs_pkg::NBR_W'(lgrs_pkg::SURVIVE_COUNT)));
   assign tail_bit = (n_tail == lgrs_pkg::NBR_W'(lgrs_pkg::BIRTH_COUNT))
                   | (row_bit & (n_tail == lgrs_pkg::NBR_W'(lgrs_pkg::SURVIVE_COUNT)));

   always_comb begin
      above_in = above_ff;
      mid_in   = mid_ff;
      if (ctl.load) begin
         above_in = up_c;
         mid_in   = row_bit;
      end
   end

   always_ff @(posedge clock) begin
      above_ff <= above_in;
      mid_ff   <= mid_in;
   end

endmodule

/* hdl/lgrs_row.sv */
module lgrs_row (
   input  logic                         clock,
   input  lgrs_pkg::cell_ctl_type       ctl,
   input  logic [lgrs_pkg::ROW_W-1:0]   row_cells,
   output logic [lgrs_pkg::ROW_W-1:0]   next_cells,
   output logic [lgrs_pkg::ROW_W-1:0]   tail_cells
);

   logic [lgrs_pkg::ROW_W-1:0] row_bits;
   logic [lgrs_pkg::ROW_W-1:0] above_bits;
   logic [lgrs_pkg::ROW_W-1:0] mid_bits;
   logic [lgrs_pkg::ROW_W+1:0] row_pad;
   logic [lgrs_pkg::ROW_W+1:0] above_pad;
   logic [lgrs_pkg::ROW_W+1:0] mid_pad;

   assign row_pad   = {1'b0, row_bits, 1'b0};
   assign above_pad = {1'b0, above_bits, 1'b0};
   assign mid_pad   = {1'b0, mid_bits, 1'b0};

   for (genvar i = 0; i < lgrs_pkg::ROW_W; i++) begin : g_col
      if (i < lgrs_pkg::GRID_WIDTH) begin : g_cell
         assign row_bits[i] = row_cells[i];
         lgrs_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .row_bit     (row_bits[i]),
            .row_left    (row_pad[i]),
            .row_right   (row_pad[i+2]),
            .above_left  (above_pad[i]),
            .above_right (above_pad[i+2]),
            .mid_left    (mid_pad[i]),
            .mid_right   (mid_pad[i+2]),
            .above_bit   (above_bits[i]),
            .mid_bit     (mid_bits[i]),
            .next_bit    (next_cells[i]),
            .tail_bit    (tail_cells[i])
         );
      end else begin : g_off
         assign row_bits[i]   = 1'b0;
         assign above_bits[i] = 1'b0;
         assign mid_bits[i]   = 1'b0;
         assign next_cells[i] = 1'b0;
         assign tail_cells[i] = 1'b0;
      end
   end

endmodule

/* hdl/lgrs_queue.sv */
`include "life_generation_row_stream_top_macros.svh"

module lgrs_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  lgrs_pkg::push_type    push,
   input  lgrs_pkg::result_type  first_entry,
   input  lgrs_pkg::result_type  second_entry,
   output logic                  space,
   output logic                  out_valid,
   input  logic                  out_ready,
   output lgrs_pkg::result_type  out_entry
);

   lgrs_pkg::result_type        entry_ff [lgrs_pkg::QUEUE_DEPTH];
   logic [lgrs_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lgrs_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lgrs_pkg::QCNT_W-1:0] count_ff, count_in;
   logic [lgrs_pkg::QPTR_W-1:0] wr_next;
   logic                        pop;
   logic [1:0]                  push_n;

   assign space     = count_ff <= lgrs_pkg::QCNT_W'(lgrs_pkg::QUEUE_DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_entry = entry_ff[rd_ptr_ff];
   assign pop       = out_valid & out_ready;
   assign push_n    = 2'(push.first) + 2'(push.second);
   assign wr_next   = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + lgrs_pkg::QPTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + lgrs_pkg::QPTR_W'(pop);
      count_in  = count_ff + lgrs_pkg::QCNT_W'(push_n) - lgrs_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         entry_ff[wr_ptr_ff] <= first_entry;
         if (push.second) begin
            entry_ff[wr_next] <= second_entry;
         end
      end else if (push.second) begin
         entry_ff[wr_ptr_ff] <= second_entry;
      end
   end

   `LGRS_ASSERT_NOW(a_count_bound, clock, reset, 1'b1,
      count_ff <= lgrs_pkg::QCNT_W'(lgrs_pkg::QUEUE_DEPTH))
   `LGRS_ASSERT_NOW(a_push_room, clock, reset, push.first || push.second, space)
   `LGRS_ASSERT_NEXT(a_pop_only, clock, reset, pop && !push.first && !push.second,
      count_ff == $past(count_ff) - 1'b1)

endmodule

/* hdl/life_generation_row_stream_top.sv */
// Results of an accepted request are registered in the output queue and offered on rsp_ behind older ones.
// Throughput: one request per cycle while two queue slots are free; a final row yields up
// to two results, which the output queue drains one per cycle while rsp_ready is high.
// The column cells hold the two previous rows; one flag, whether a row is held, is the only control.
// Reset (synchronous, active high) empties the held rows and the output queue.
`include "life_generation_row_stream_top_macros.svh"

module life_generation_row_stream_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [lgrs_pkg::ROW_W-1:0] req_row_cells,
   input  logic                       req_final_row,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [lgrs_pkg::ROW_W-1:0] rsp_next_cells,
   output logic                       rsp_frame_end
);

   logic                       held_ff, held_in;
   logic                       accept;
   logic                       space;
   lgrs_pkg::cell_ctl_type     ctl;
   lgrs_pkg::push_type         push;
   lgrs_pkg::result_type       first_entry;
   lgrs_pkg::result_type       second_entry;
   lgrs_pkg::result_type       out_entry;
   logic [lgrs_pkg::ROW_W-1:0] next_cells;
   logic [lgrs_pkg::ROW_W-1:0] tail_cells;

   assign req_ready = space;
   assign accept    = req_valid & req_ready;

   assign ctl.load = accept;
   assign ctl.held = held_ff;

   assign push.first  = accept & held_ff;
   assign push.second = accept & req_final_row;

   assign first_entry.cells      = next_cells;
   assign first_entry.frame_end  = 1'b0;
   assign second_entry.cells     = tail_cells;
   assign second_entry.frame_end = 1'b1;

   assign rsp_next_cells = out_entry.cells;
   assign rsp_frame_end  = out_entry.frame_end;

   always_comb begin
      held_in = held_ff;
      if (accept) begin
         held_in = ~req_final_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
      end else begin
         held_ff <= held_in;
      end
   end

   lgrs_row u_row (
      .clock      (clock),
      .ctl        (ctl),
      .row_cells  (req_row_cells),
      .next_cells (next_cells),
      .tail_cells (tail_cells)
   );

   lgrs_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .first_entry  (first_entry),
      .second_entry (second_entry),
      .space        (space),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_entry    (out_entry)
   );

   `LGRS_ASSERT_NEXT(a_final_empties, clock, reset, accept && req_final_row, !held_ff)
   `LGRS_ASSERT_NEXT(a_row_held, clock, reset, accept && !req_final_row, held_ff)
   `LGRS_ASSERT_NEXT(a_result_shown, clock, reset, accept && (held_ff || req_final_row),
      rsp_valid)

endmodule

/* tb/life_generation_row_stream_top_tb.sv */
`timescale 1ns / 1ps

module life_generation_row_stream_top_tb;

   localparam int IDLE_LIMIT   = 1000;
   localparam int HOLD_CYCLES  = 200;
   localparam int HOLD_AT      = 500;
   localparam int RANDOM_ROWS  = 2000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct {
      logic [lgrs_pkg::ROW_W-1:0] cells;
      logic                       last;
   } grid_row_type;

   typedef enum int {
      ROW_RANDOM,
      ROW_SPARSE,
      ROW_DENSE,
      ROW_EMPTY,
      ROW_FULL,
      ROW_ONE_CELL,
      ROW_KIND_COUNT
   } row_kind_type;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [lgrs_pkg::ROW_W-1:0] req_row_cells = '0;
   logic                       req_final_row = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [lgrs_pkg::ROW_W-1:0] rsp_next_cells;
   logic                       rsp_frame_end;

   grid_row_type               pending_rows[$];
   lgrs_pkg::result_type       expected_gens[$];

   logic [lgrs_pkg::ROW_W-1:0] held_above;
   logic [lgrs_pkg::ROW_W-1:0] held_middle;
   int                         held_count;

   int                         rows_sent;
   int                         gens_checked;
   int                         grids_queued;
   int                         single_grids;
   int                         bad_rows;
   int                         req_gap;
   int                         rsp_stall;
   int                         hold_left;
   bit                         hold_done;
   int                         idle_cycles;
   int                         draw;
   grid_row_type               launch_row;
   lgrs_pkg::result_type       oldest_gen;

   life_generation_row_stream_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_row_cells  (req_row_cells),
      .req_final_row  (req_final_row),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_next_cells (rsp_next_cells),
      .rsp_frame_end  (rsp_frame_end)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int alive_at(input logic [lgrs_pkg::ROW_W-1:0] row, input int col);
      if (col < 0 || col >= lgrs_pkg::GRID_WIDTH)
         return 0;
      return int'(row[col]);
   endfunction

   function automatic logic [lgrs_pkg::ROW_W-1:0] life_generation(
      input logic [lgrs_pkg::ROW_W-1:0] up,
      input logic [lgrs_pkg::ROW_W-1:0] mid,
      input logic [lgrs_pkg::ROW_W-1:0] down);
      logic [lgrs_pkg::ROW_W-1:0] gen;
      int                         nbrs;
      gen = '0;
      for (int i = 0; i < lgrs_pkg::GRID_WIDTH; i++) begin
         nbrs = alive_at(up, i - 1) + alive_at(up, i) + alive_at(up, i + 1)
              + alive_at(mid, i - 1) + alive_at(mid, i + 1)
              + alive_at(down, i - 1) + alive_at(down, i) + alive_at(down, i + 1);
         if (nbrs == lgrs_pkg::BIRTH_COUNT
             || (alive_at(mid, i) == 1 && nbrs == lgrs_pkg::SURVIVE_COUNT))
            gen[i] = 1'b1;
      end
      return gen;
   endfunction

   task automatic predict_generations(input logic [lgrs_pkg::ROW_W-1:0] cells,
                                      input logic last);
      lgrs_pkg::result_type gen;
      if (held_count == 0) begin
         held_above  = '0;
         held_middle = cells;
         held_count  = 1;
      end else begin
         gen.cells     = life_generation(held_above, held_middle, cells);
         gen.frame_end = 1'b0;
         expected_gens = {expected_gens, gen};
         held_above  = held_middle;
         held_middle = cells;
         held_count  = 2;
      end
      if (last) begin
         gen.cells     = life_generation(held_above, held_middle, '0);
         gen.frame_end = 1'b1;
         expected_gens = {expected_gens, gen};
         held_above  = '0;
         held_middle = '0;
         held_count  = 0;
      end
   endtask

   task automatic queue_row(input logic [lgrs_pkg::ROW_W-1:0] cells, input logic last);
      grid_row_type r;
      r.cells = cells;
      r.last  = last;
      pending_rows = {pending_rows, r};
   endtask

   function automatic logic [lgrs_pkg::ROW_W-1:0] random_row(input row_kind_type kind);
      logic [lgrs_pkg::ROW_W-1:0] a;
      logic [lgrs_pkg::ROW_W-1:0] b;
      a = {$urandom(), $urandom()};
      b = {$urandom(), $urandom()};
      case (kind)
         ROW_SPARSE:   return a & b & {$urandom(), $urandom()};
         ROW_DENSE:    return a | b;
         ROW_EMPTY:    return '0;
         ROW_FULL:     return '1;
         ROW_ONE_CELL: return {{(lgrs_pkg::ROW_W-1){1'b0}}, 1'b1}
                              << $urandom_range(0, lgrs_pkg::ROW_W - 1);
         default:      return a;
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_generations(req_row_cells, req_final_row);
            rows_sent++;
         end
         if (req_valid && !req_ready) begin
            // hold
         end else if (req_gap > 0) begin
            req_gap   <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_rows.size() > 0) begin
            launch_row    = pending_rows.pop_front();
            req_valid     <= 1'b1;
            req_row_cells <= launch_row.cells;
            req_final_row <= launch_row.last;
            req_gap       <= ((rows_sent / 100) % 4 == 0) ? 0 : $urandom_range(0, 6);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && gens_checked >= HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            gens_checked++;
            if (expected_gens.size() == 0) begin
               bad_rows++;
               if (bad_rows <= 10)
                  $display("unexpected result row: cells %h frame_end %b",
                           rsp_next_cells, rsp_frame_end);
            end else begin
               oldest_gen = expected_gens.pop_front();
               if (rsp_next_cells !== oldest_gen.cells
                   || rsp_frame_end !== oldest_gen.frame_end) begin
                  bad_rows++;
                  if (bad_rows <= 10)
                     $display("result row %0d: expected cells %h frame_end %b, got %h %b",
                              gens_checked, oldest_gen.cells, oldest_gen.frame_end,
                              rsp_next_cells, rsp_frame_end);
               end
            end
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
         end else if (rsp_valid && rsp_ready) begin
            draw = ((gens_checked / 120) % 3 == 0) ? 0 : $urandom_range(0, 6);
            if (draw == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               rsp_stall <= draw - 1;
            end
         end else if (rsp_stall > 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("no request or result moved for %0d cycles", IDLE_LIMIT);
         $display("life_generation_row_stream_top verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int           grid_len;
      int           queued;
      row_kind_type kind;

      held_above  = '0;
      held_middle = '0;
      held_count  = 0;

      // single-row grids: all alive, all dead, edge cells
      queue_row('1, 1'b1);
      queue_row('0, 1'b1);
      queue_row(64'h8000_0000_0000_0003, 1'b1);
      single_grids += 3;
      // dead, full, full, dead
      queue_row('0, 1'b0);
      queue_row('1, 1'b0);
      queue_row('1, 1'b0);
      queue_row('0, 1'b1);
      // vertical blinker
      queue_row(64'h20, 1'b0);
      queue_row(64'h20, 1'b0);
      queue_row(64'h20, 1'b1);
      // glider against the highest outer column
      queue_row(64'h4000_0000_0000_0000, 1'b0);
      queue_row(64'h8000_0000_0000_0000, 1'b0);
      queue_row(64'hE000_0000_0000_0000, 1'b0);
      queue_row(64'h0, 1'b1);
      // two-row grid with corner cells
      queue_row(64'h8000_0000_0000_0001, 1'b0);
      queue_row(64'h8000_0000_0000_0001, 1'b1);
      // checkerboard rows
      queue_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      queue_row(64'h5555_5555_5555_5555, 1'b0);
      queue_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
      // block at column 0
      queue_row(64'h3, 1'b0);
      queue_row(64'h3, 1'b0);
      queue_row(64'h0, 1'b1);
      grids_queued = 9;

      queued = pending_rows.size();
      while (queued < RANDOM_ROWS + 22) begin
         draw = $urandom_range(0, 19);
         if (draw == 0)
            grid_len = 1;
         else if (draw < 3)
            grid_len = $urandom_range(9, 40);
         else
            grid_len = $urandom_range(1, 8);
         if (grid_len == 1)
            single_grids++;
         kind = row_kind_type'($urandom_range(0, ROW_KIND_COUNT - 1));
         for (int r = 0; r < grid_len; r++) begin
            if ($urandom_range(0, 3) == 0)
               kind = row_kind_type'($urandom_range(0, ROW_KIND_COUNT - 1));
            queue_row(random_row(kind), r == grid_len - 1);
         end
         queued += grid_len;
         grids_queued++;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      @(posedge clock);
      while (pending_rows.size() > 0 || req_valid || expected_gens.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("streamed %0d grids (%0d of a single row), %0d rows in", grids_queued,
               single_grids, rows_sent);
      $display("%0d result rows checked, %0d bad", gens_checked, bad_rows);
      if (bad_rows == 0 && expected_gens.size() == 0) begin
         $display("life_generation_row_stream_top verification clean");
      end else begin
         $display("life_generation_row_stream_top verification failed");
      end
      $finish;
   end

endmodule
